// ===== design/vehicle_alarm_hazard_controller_top_defines.svh =====
// Assertion macros shared by the vehicle alarm and hazard controller.
`ifndef VEHICLE_ALARM_HAZARD_CONTROLLER_TOP_DEFINES_SVH
`define VEHICLE_ALARM_HAZARD_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define VAHC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define VAHC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VAHC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define VAHC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== design/vahc_pkg.sv =====
package vahc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int CSR_ADDR_WIDTH      = 5;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int REQ_DATA_WIDTH      = 24;
   localparam int RSP_DATA_WIDTH      = 8;

   typedef enum logic [2:0] {
      REG_HOLD_MS          = 3'd0,
      REG_HAZARD_TOGGLE_MS = 3'd1,
      REG_AUTO_HAZARD      = 3'd2,
      REG_BRAKE_THRESHOLD  = 3'd3,
      REG_PULSE_LENGTH_MS  = 3'd4,
      REG_SHOCK_THRESHOLD  = 3'd5,
      REG_ALARM_TOGGLE_MS  = 3'd6
   } reg_index_type;

   localparam logic [15:0] HOLD_MS_RESET          = 16'd1000;
   localparam logic [15:0] HAZARD_TOGGLE_MS_RESET = 16'd300;
   localparam logic        AUTO_HAZARD_RESET      = 1'b1;
   localparam logic [6:0]  BRAKE_THRESHOLD_RESET  = 7'd50;
   localparam logic [15:0] PULSE_LENGTH_MS_RESET  = 16'd3000;
   localparam logic [11:0] SHOCK_THRESHOLD_RESET  = 12'd358;
   localparam logic [15:0] ALARM_TOGGLE_MS_RESET  = 16'd100;

   typedef struct packed {
      logic [15:0] alarm_toggle_ms;
      logic [11:0] shock_threshold;
      logic [15:0] pulse_length_ms;
      logic [6:0]  brake_threshold;
      logic        auto_hazard_enable;
      logic [15:0] hazard_toggle_ms;
      logic [15:0] hold_ms;
   } cfg_type;

   // Field order follows tdata from the highest bit down.
   typedef struct packed {
      logic [11:0] total_gforce;
      logic [6:0]  brake_intensity;
      logic        button_c;
      logic        button_b;
      logic        button_a;
   } req_type;

   typedef struct packed {
      logic engine_start;
      logic status_blink_req;
      logic single_blink_req;
      logic signal_out;
      logic alarm_active;
      logic alarm_armed;
      logic system_on;
   } rsp_type;

endpackage

// ===== design/vahc_csr.sv =====
module vahc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [vahc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [vahc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [vahc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output vahc_pkg::cfg_type                    cfg
);

   vahc_pkg::cfg_type       cfg_ff;
   vahc_pkg::cfg_type       cfg_in;
   vahc_pkg::reg_index_type index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign index      = vahc_pkg::reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            vahc_pkg::REG_HOLD_MS:          cfg_in.hold_ms = csr_pwdata[15:0];
            vahc_pkg::REG_HAZARD_TOGGLE_MS: cfg_in.hazard_toggle_ms = csr_pwdata[15:0];
            vahc_pkg::REG_AUTO_HAZARD:      cfg_in.auto_hazard_enable = csr_pwdata[0];
            vahc_pkg::REG_BRAKE_THRESHOLD:  cfg_in.brake_threshold = csr_pwdata[6:0];
            vahc_pkg::REG_PULSE_LENGTH_MS:  cfg_in.pulse_length_ms = csr_pwdata[15:0];
            vahc_pkg::REG_SHOCK_THRESHOLD:  cfg_in.shock_threshold = csr_pwdata[11:0];
            vahc_pkg::REG_ALARM_TOGGLE_MS:  cfg_in.alarm_toggle_ms = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         vahc_pkg::REG_HOLD_MS:          csr_prdata = 32'(cfg_ff.hold_ms);
         vahc_pkg::REG_HAZARD_TOGGLE_MS: csr_prdata = 32'(cfg_ff.hazard_toggle_ms);
         vahc_pkg::REG_AUTO_HAZARD:      csr_prdata = 32'(cfg_ff.auto_hazard_enable);
         vahc_pkg::REG_BRAKE_THRESHOLD:  csr_prdata = 32'(cfg_ff.brake_threshold);
         vahc_pkg::REG_PULSE_LENGTH_MS:  csr_prdata = 32'(cfg_ff.pulse_length_ms);
         vahc_pkg::REG_SHOCK_THRESHOLD:  csr_prdata = 32'(cfg_ff.shock_threshold);
         vahc_pkg::REG_ALARM_TOGGLE_MS:  csr_prdata = 32'(cfg_ff.alarm_toggle_ms);
         default:                        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ms            <= vahc_pkg::HOLD_MS_RESET;
         cfg_ff.hazard_toggle_ms   <= vahc_pkg::HAZARD_TOGGLE_MS_RESET;
         cfg_ff.auto_hazard_enable <= vahc_pkg::AUTO_HAZARD_RESET;
         cfg_ff.brake_threshold    <= vahc_pkg::BRAKE_THRESHOLD_RESET;
         cfg_ff.pulse_length_ms    <= vahc_pkg::PULSE_LENGTH_MS_RESET;
         cfg_ff.shock_threshold    <= vahc_pkg::SHOCK_THRESHOLD_RESET;
         cfg_ff.alarm_toggle_ms    <= vahc_pkg::ALARM_TOGGLE_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/vahc_step.sv =====
module vahc_step #(
   parameter int COUNT_WIDTH = vahc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  vahc_pkg::req_type req,
   input  vahc_pkg::cfg_type cfg,
   output vahc_pkg::rsp_type rsp
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   typedef struct packed {
      logic                   sys_on;
      logic                   armed;
      logic                   triggered;
      logic                   a_down;
      logic                   a_hold_done;
      logic [COUNT_WIDTH-1:0] a_press_count;
      logic                   b_down;
      logic                   b_hold_done;
      logic [COUNT_WIDTH-1:0] b_press_count;
      logic                   pulse_active;
      logic [COUNT_WIDTH-1:0] pulse_elapsed;
      logic [COUNT_WIDTH-1:0] hazard_elapsed;
      logic                   hazard_phase;
      logic [COUNT_WIDTH-1:0] alarm_elapsed;
      logic                   alarm_phase;
      logic                   signal_level;
   } state_type;

   state_type state_ff;
   state_type state_in;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic reached(input logic [COUNT_WIDTH-1:0] count,
                                    input logic [15:0] limit);
      return CMP_WIDTH'(count) >= CMP_WIDTH'(limit);
   endfunction

   always_comb begin
      state_type s;
      logic      single_req;
      logic      status_req;
      logic      engine;
      s          = state_ff;
      single_req = 1'b0;
      status_req = 1'b0;

      if (s.pulse_active) begin
         s.pulse_elapsed  = sat_inc(s.pulse_elapsed);
         s.hazard_elapsed = sat_inc(s.hazard_elapsed);
      end
      s.alarm_elapsed = sat_inc(s.alarm_elapsed);

      // Power button: short press turns on, hold turns off.
      if (req.button_a) begin
         if (!s.a_down) begin
            s.a_down        = 1'b1;
            s.a_press_count = '0;
         end else begin
            s.a_press_count = sat_inc(s.a_press_count);
         end
         if (!s.a_hold_done && reached(s.a_press_count, cfg.hold_ms)) begin
            if (s.sys_on) begin
               s.sys_on   = 1'b0;
               single_req = 1'b1;
            end
            s.a_hold_done = 1'b1;
         end
      end else begin
         if (s.a_down && !s.a_hold_done) begin
            if (s.triggered) begin
               s.triggered = 1'b0;
               single_req  = 1'b1;
            end
            s.sys_on = 1'b1;
         end
         s.a_down        = 1'b0;
         s.a_hold_done   = 1'b0;
         s.a_press_count = '0;
      end

      // Alarm button: hold toggles arming while off, short press clears or asks status.
      if (req.button_b) begin
         if (!s.b_down) begin
            s.b_down        = 1'b1;
            s.b_press_count = '0;
         end else begin
            s.b_press_count = sat_inc(s.b_press_count);
         end
         if (!s.b_hold_done && reached(s.b_press_count, cfg.hold_ms) &&
             !s.triggered && !s.sys_on) begin
            s.b_hold_done = 1'b1;
            s.armed       = !s.armed;
            if (s.armed) begin
               status_req = 1'b1;
            end else begin
               single_req = 1'b1;
            end
         end
      end else begin
         if (s.b_down && !s.b_hold_done) begin
            if (s.triggered) begin
               s.triggered = 1'b0;
               single_req  = 1'b1;
            end else if (!s.sys_on) begin
               status_req = 1'b1;
            end
         end
         s.b_down        = 1'b0;
         s.b_hold_done   = 1'b0;
         s.b_press_count = '0;
      end

      engine = req.button_c & s.sys_on;

      if ((req.brake_intensity > cfg.brake_threshold) && !s.pulse_active &&
          s.sys_on && cfg.auto_hazard_enable) begin
         s.pulse_active   = 1'b1;
         s.pulse_elapsed  = '0;
         s.hazard_elapsed = '0;
         s.hazard_phase   = 1'b0;
      end
      if (s.pulse_active) begin
         if (reached(s.pulse_elapsed, cfg.pulse_length_ms)) begin
            s.pulse_active = 1'b0;
            s.signal_level = 1'b0;
         end else if (reached(s.hazard_elapsed, cfg.hazard_toggle_ms)) begin
            s.hazard_elapsed = '0;
            s.hazard_phase   = !s.hazard_phase;
            s.signal_level   = s.hazard_phase;
         end
      end

      if (!s.sys_on && (req.total_gforce > cfg.shock_threshold) && s.armed) begin
         s.triggered = 1'b1;
      end
      if (s.triggered && s.armed && reached(s.alarm_elapsed, cfg.alarm_toggle_ms)) begin
         s.alarm_elapsed = '0;
         s.alarm_phase   = !s.alarm_phase;
         s.signal_level  = s.alarm_phase;
      end

      state_in             = s;
      rsp.system_on        = s.sys_on;
      rsp.alarm_armed      = s.armed;
      rsp.alarm_active     = s.triggered;
      rsp.signal_out       = s.signal_level;
      rsp.single_blink_req = single_req;
      rsp.status_blink_req = status_req;
      rsp.engine_start     = engine;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/vehicle_alarm_hazard_controller_top.sv =====
// Vehicle alarm and hazard controller: each request is one 1 ms tick with button
// levels, braking intensity and g-force, and yields exactly one response with the
// relay levels and one-tick blink requests. A request is taken every cycle while
// responses are taken; its response passes through the input register and then the
// result register, with the state update between them. The user must write registers
// over the APB port only while no request is in flight; the block does not enforce it.
`include "vehicle_alarm_hazard_controller_top_defines.svh"

module vehicle_alarm_hazard_controller_top #(
   parameter int COUNT_WIDTH = vahc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] button_a, [1] button_b, [2] button_c, [9:3] brake_intensity,
   // [21:10] total_gforce, [23:22] zero
   input  logic [vahc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] system_on, [1] alarm_armed, [2] alarm_active, [3] signal_out,
   // [4] single_blink_req, [5] status_blink_req, [6] engine_start, [7] zero
   output logic [vahc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [vahc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [vahc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [vahc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   vahc_pkg::cfg_type cfg;
   vahc_pkg::req_type in_data_ff;
   vahc_pkg::rsp_type step_rsp;
   vahc_pkg::rsp_type out_data_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              req_accept;
   logic              advance;

   assign advance     = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready  = ~in_valid_ff | advance;
   assign req_accept  = req_tvalid & req_tready;
   assign in_valid_in = req_accept | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = {1'b0, out_data_ff};

   vahc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vahc_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_accept) begin
         in_data_ff <= vahc_pkg::req_type'(req_tdata[21:0]);
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   `VAHC_ASSERT_NEXT(a_advance_gives_rsp, clock, reset, advance, rsp_tvalid)
   `VAHC_ASSERT_IMPLY(a_stall_means_full, clock, reset, !req_tready, in_valid_ff && out_valid_ff)
   `VAHC_ASSERT_IMPLY(a_active_needs_armed, clock, reset, rsp_tvalid && rsp_tdata[2], rsp_tdata[1])
   `VAHC_ASSERT_IMPLY(a_engine_needs_on, clock, reset, rsp_tvalid && rsp_tdata[6], rsp_tdata[0])

endmodule

// ===== bench/vehicle_alarm_hazard_controller_top_test.sv =====
module vehicle_alarm_hazard_controller_top_test;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // [0] button_a, [1] button_b, [2] button_c, [9:3] brake_intensity,
   // [21:10] total_gforce, [23:22] zero
   logic [vahc_pkg::REQ_DATA_WIDTH-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // [0] system_on, [1] alarm_armed, [2] alarm_active, [3] signal_out,
   // [4] single_blink_req, [5] status_blink_req, [6] engine_start, [7] zero
   logic [vahc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [vahc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [vahc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [vahc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   vehicle_alarm_hazard_controller_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   logic [31:0] cfg_regs [7];
   vahc_pkg::rsp_type expected_status [$];
   int errors = 0;
   int idle_pct = 0;
   int stall_left = 0;
   int cycle_count = 0;
   string field_names [7] = '{"system_on", "alarm_armed", "alarm_active", "signal_out",
                              "single_blink_req", "status_blink_req", "engine_start"};

   logic        power_on = 1'b0;
   logic        is_armed = 1'b0;
   logic        tripped = 1'b0;
   logic        a_pressed = 1'b0;
   logic        a_hold_seen = 1'b0;
   logic [15:0] a_ms = '0;
   logic        b_pressed = 1'b0;
   logic        b_hold_seen = 1'b0;
   logic [15:0] b_ms = '0;
   logic        flash_on = 1'b0;
   logic [15:0] flash_ms = '0;
   logic [15:0] hazard_ms = '0;
   logic        hazard_level = 1'b0;
   logic [15:0] alarm_ms = '0;
   logic        alarm_level = 1'b0;
   logic        relay = 1'b0;

   function automatic logic [15:0] sat_inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic vahc_pkg::rsp_type advance_controller(vahc_pkg::req_type r);
      vahc_pkg::rsp_type o;
      o = '0;
      if (flash_on) begin
         flash_ms = sat_inc(flash_ms);
         hazard_ms = sat_inc(hazard_ms);
      end
      alarm_ms = sat_inc(alarm_ms);

      if (r.button_a) begin
         if (!a_pressed) begin
            a_pressed = 1'b1;
            a_ms = '0;
         end else begin
            a_ms = sat_inc(a_ms);
         end
         if (!a_hold_seen && a_ms >= cfg_regs[vahc_pkg::REG_HOLD_MS][15:0]) begin
            if (power_on) begin
               power_on = 1'b0;
               o.single_blink_req = 1'b1;
            end
            a_hold_seen = 1'b1;
         end
      end else begin
         if (a_pressed && !a_hold_seen) begin
            if (tripped) begin
               tripped = 1'b0;
               o.single_blink_req = 1'b1;
            end
            power_on = 1'b1;
         end
         a_pressed = 1'b0;
         a_hold_seen = 1'b0;
         a_ms = '0;
      end

      if (r.button_b) begin
         if (!b_pressed) begin
            b_pressed = 1'b1;
            b_ms = '0;
         end else begin
            b_ms = sat_inc(b_ms);
         end
         if (!b_hold_seen && b_ms >= cfg_regs[vahc_pkg::REG_HOLD_MS][15:0] && !tripped &&
             !power_on) begin
            b_hold_seen = 1'b1;
            is_armed = !is_armed;
            if (is_armed) begin
               o.status_blink_req = 1'b1;
            end else begin
               o.single_blink_req = 1'b1;
            end
         end
      end else begin
         if (b_pressed && !b_hold_seen) begin
            if (tripped) begin
               tripped = 1'b0;
               o.single_blink_req = 1'b1;
            end else if (!power_on) begin
               o.status_blink_req = 1'b1;
            end
         end
         b_pressed = 1'b0;
         b_hold_seen = 1'b0;
         b_ms = '0;
      end

      o.engine_start = r.button_c && power_on;

      if (r.brake_intensity > cfg_regs[vahc_pkg::REG_BRAKE_THRESHOLD][6:0] && !flash_on &&
          power_on && cfg_regs[vahc_pkg::REG_AUTO_HAZARD][0]) begin
         flash_on = 1'b1;
         flash_ms = '0;
         hazard_ms = '0;
         hazard_level = 1'b0;
      end
      if (flash_on) begin
         if (flash_ms >= cfg_regs[vahc_pkg::REG_PULSE_LENGTH_MS][15:0]) begin
            flash_on = 1'b0;
            relay = 1'b0;
         end else if (hazard_ms >= cfg_regs[vahc_pkg::REG_HAZARD_TOGGLE_MS][15:0]) begin
            hazard_ms = '0;
            hazard_level = !hazard_level;
            relay = hazard_level;
         end
      end

      if (!power_on && r.total_gforce > cfg_regs[vahc_pkg::REG_SHOCK_THRESHOLD][11:0] &&
          is_armed) begin
         tripped = 1'b1;
      end
      if (tripped && is_armed &&
          alarm_ms >= cfg_regs[vahc_pkg::REG_ALARM_TOGGLE_MS][15:0]) begin
         alarm_ms = '0;
         alarm_level = !alarm_level;
         relay = alarm_level;
      end

      o.system_on = power_on;
      o.alarm_armed = is_armed;
      o.alarm_active = tripped;
      o.signal_out = relay;
      return o;
   endfunction

   function automatic int pick_gap();
      return ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
   endfunction

   function automatic logic [31:0] field_mask(vahc_pkg::reg_index_type idx);
      case (idx)
         vahc_pkg::REG_AUTO_HAZARD: return 32'h1;
         vahc_pkg::REG_BRAKE_THRESHOLD: return 32'h7F;
         vahc_pkg::REG_SHOCK_THRESHOLD: return 32'hFFF;
         default: return 32'hFFFF;
      endcase
   endfunction

   function automatic int run_length(bit pressed, int hold);
      if (!pressed) begin
         return $urandom_range(6, 1);
      end
      if (hold > 0 && $urandom_range(1) == 1) begin
         return $urandom_range((hold < 8) ? hold : 8, 1);
      end
      return hold + 1 + $urandom_range(2);
   endfunction

   task automatic check_status(logic [vahc_pkg::RSP_DATA_WIDTH-1:0] data);
      vahc_pkg::rsp_type want;
      vahc_pkg::rsp_type got;
      if (expected_status.size() == 0) begin
         $error("response 0x%0h arrived with no request outstanding", data);
         errors++;
      end else begin
         want = expected_status.pop_front();
         got = data[6:0];
         for (int i = 0; i < 7; i++) begin
            if (got[i] !== want[i]) begin
               $error("%s expected %0d got %0d", field_names[i], want[i], got[i]);
               errors++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_status(rsp_tdata);
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(99) < idle_pct) begin
         stall_left = pick_gap();
      end
      rsp_tready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("vehicle_alarm_hazard_controller_top_test NOT OK");
         $finish;
      end
   end

   task automatic send_request(vahc_pkg::req_type r);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= vahc_pkg::REQ_DATA_WIDTH'(r);
      do @(posedge clock); while (!req_tready);
      expected_status.push_back(advance_controller(r));
   endtask

   task automatic send_levels(bit a, bit b, bit c, int brake, int gforce);
      vahc_pkg::req_type r;
      r.button_a = a;
      r.button_b = b;
      r.button_c = c;
      r.brake_intensity = 7'(brake);
      r.total_gforce = 12'(gforce);
      send_request(r);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(vahc_pkg::reg_index_type idx, int value);
      logic [31:0] mask;
      logic [31:0] junk;
      mask = field_mask(idx);
      junk = ($urandom_range(3) == 0) ? ($urandom & ~mask) : 32'h0;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= (32'(value) & mask) | junk;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      cfg_regs[idx] = 32'(value) & mask;
   endtask

   task automatic csr_check(vahc_pkg::reg_index_type idx);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (csr_prdata !== cfg_regs[idx]) begin
         $error("%s expected %0d got %0d", idx.name(), cfg_regs[idx], csr_prdata);
         errors++;
      end
   endtask

   task automatic verify_registers();
      for (int i = 0; i < 7; i++) begin
         csr_check(vahc_pkg::reg_index_type'(i));
      end
   endtask

   task automatic set_config(int hold, int hazard_toggle, int auto_on, int brake_thr,
                             int pulse_len, int shock_thr, int alarm_toggle);
      wait_drained();
      csr_write(vahc_pkg::REG_HOLD_MS, hold);
      csr_write(vahc_pkg::REG_HAZARD_TOGGLE_MS, hazard_toggle);
      csr_write(vahc_pkg::REG_AUTO_HAZARD, auto_on);
      csr_write(vahc_pkg::REG_BRAKE_THRESHOLD, brake_thr);
      csr_write(vahc_pkg::REG_PULSE_LENGTH_MS, pulse_len);
      csr_write(vahc_pkg::REG_SHOCK_THRESHOLD, shock_thr);
      csr_write(vahc_pkg::REG_ALARM_TOGGLE_MS, alarm_toggle);
      verify_registers();
   endtask

   task automatic run_random_ticks(int count);
      vahc_pkg::req_type r;
      bit a_lvl;
      bit b_lvl;
      bit c_lvl;
      int a_left;
      int b_left;
      int c_left;
      int hold;
      a_lvl = 1'b1;
      b_lvl = 1'b1;
      c_lvl = 1'b1;
      a_left = 0;
      b_left = 0;
      c_left = 0;
      hold = cfg_regs[vahc_pkg::REG_HOLD_MS];
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            idle_pct = (idle_pct == 0) ? 30 : 0;
         end
         if (a_left == 0) begin
            a_lvl = !a_lvl;
            a_left = run_length(a_lvl, hold);
         end
         if (b_left == 0) begin
            b_lvl = !b_lvl;
            b_left = run_length(b_lvl, hold);
         end
         if (c_left == 0) begin
            c_lvl = !c_lvl;
            c_left = $urandom_range(4, 1);
         end
         a_left--;
         b_left--;
         c_left--;
         r.button_a = a_lvl;
         r.button_b = b_lvl;
         r.button_c = c_lvl;
         r.brake_intensity =
            7'(($urandom_range(3) == 0) ? $urandom_range(100) : $urandom_range(30));
         r.total_gforce =
            12'(($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(255));
         if ($urandom_range(9) == 0) begin
            r.button_a = 1'($urandom_range(1));
            r.button_b = 1'($urandom_range(1));
            r.button_c = 1'($urandom_range(1));
         end
         send_request(r);
      end
   endtask

   task automatic test_reset_state();
      idle_pct = 25;
      verify_registers();
      send_levels(1, 0, 0, 0, 0);
      send_levels(0, 0, 1, 0, 0);
      send_levels(0, 0, 0, 51, 0);
      send_levels(0, 0, 0, 0, 4095);
   endtask

   task automatic test_button_sequences();
      set_config(2, 1, 1, 99, 3, 0, 1);
      idle_pct = 25;
      send_levels(0, 0, 0, 0, 4095);
      repeat (3) send_levels(0, 1, 0, 0, 0);
      send_levels(0, 0, 0, 0, 0);
      send_levels(0, 0, 0, 0, 4095);
      send_levels(0, 0, 0, 0, 0);
      send_levels(0, 1, 0, 0, 0);
      send_levels(0, 0, 0, 0, 0);
      send_levels(0, 1, 0, 0, 0);
      send_levels(0, 0, 0, 0, 0);
      send_levels(0, 0, 0, 0, 4095);
      send_levels(1, 0, 0, 0, 0);
      send_levels(0, 0, 1, 100, 0);
      send_levels(0, 1, 1, 0, 0);
      repeat (2) send_levels(0, 1, 0, 0, 0);
      send_levels(0, 0, 0, 0, 0);
      send_levels(1, 0, 0, 100, 4095);
      repeat (2) send_levels(1, 0, 0, 0, 0);
      send_levels(1, 1, 0, 0, 0);
      send_levels(0, 0, 0, 0, 0);
   endtask

   task automatic test_typical_settings();
      set_config(3, 2, 1, 50, 12, 358, 3);
      run_random_ticks(150);
   endtask

   task automatic test_low_extremes();
      set_config(1, 1, 1, 0, 1, 0, 1);
      run_random_ticks(120);
   endtask

   task automatic test_high_extremes();
      set_config(0, 65535, 0, 100, 65535, 4095, 65535);
      run_random_ticks(100);
   endtask

   task automatic test_random_settings();
      repeat (2) begin
         set_config($urandom_range(6, 1), $urandom_range(8, 1), $urandom_range(1),
                    $urandom_range(100), $urandom_range(30, 1), $urandom_range(4095),
                    $urandom_range(8, 1));
         run_random_ticks(90);
      end
   endtask

   initial begin
      cfg_regs[vahc_pkg::REG_HOLD_MS] = 32'(vahc_pkg::HOLD_MS_RESET);
      cfg_regs[vahc_pkg::REG_HAZARD_TOGGLE_MS] = 32'(vahc_pkg::HAZARD_TOGGLE_MS_RESET);
      cfg_regs[vahc_pkg::REG_AUTO_HAZARD] = 32'(vahc_pkg::AUTO_HAZARD_RESET);
      cfg_regs[vahc_pkg::REG_BRAKE_THRESHOLD] = 32'(vahc_pkg::BRAKE_THRESHOLD_RESET);
      cfg_regs[vahc_pkg::REG_PULSE_LENGTH_MS] = 32'(vahc_pkg::PULSE_LENGTH_MS_RESET);
      cfg_regs[vahc_pkg::REG_SHOCK_THRESHOLD] = 32'(vahc_pkg::SHOCK_THRESHOLD_RESET);
      cfg_regs[vahc_pkg::REG_ALARM_TOGGLE_MS] = 32'(vahc_pkg::ALARM_TOGGLE_MS_RESET);
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_button_sequences();
      test_typical_settings();
      test_low_extremes();
      test_high_extremes();
      test_random_settings();

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("vehicle_alarm_hazard_controller_top_test OK");
      end else begin
         $display("vehicle_alarm_hazard_controller_top_test NOT OK");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/vahc_pkg.sv
design/vahc_csr.sv
design/vahc_step.sv
design/vehicle_alarm_hazard_controller_top.sv
bench/vehicle_alarm_hazard_controller_top_test.sv
